// ----- sv/assert_macros.svh -----
// Assertion helpers used by the RTL in sorted_intercept_list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A consequent that must follow its antecedent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sil_pkg.sv -----
// ----------------------------------------------------------------------------
// sil_pkg
// Types and constants shared by the sorted intercept list.
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int IN_DIST_W = 18;
  localparam int DIST_W   = 17;
  localparam int TAG_W    = 32;

  localparam logic [DIST_W-1:0] DIST_ONE = 17'h10000;

  localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRAVERSE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd3;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [IN_DIST_W-1:0] in_dist_t;
  typedef logic [DIST_W-1:0]    dist_t;
  typedef logic [TAG_W-1:0]     tag_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    dist_t    new_dist;
    logic     new_type;
  } cell_ctrl_t;

endpackage

// ----- sv/sil_req_if.sv -----
// ----------------------------------------------------------------------------
// sil_req_if
// Request channel: one operation on the intercept list per transfer.
// ----------------------------------------------------------------------------
interface sil_req_if;
  import sil_pkg::*;

  logic     valid;
  logic     ready;
  kind_t    kind;
  logic     hit_type;
  in_dist_t hit_distance;
  tag_t     object_tag;

  modport source (output valid, kind, hit_type, hit_distance, object_tag, input ready);
  modport sink (input valid, kind, hit_type, hit_distance, object_tag, output ready);
endinterface

// ----- sv/sil_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sil_rsp_if
// Result channel: one status or list entry per transfer.
// ----------------------------------------------------------------------------
interface sil_rsp_if;
  import sil_pkg::*;

  logic    valid;
  logic    ready;
  status_t add_status;
  logic    has_entry;
  logic    out_type;
  dist_t   out_distance;
  tag_t    out_tag;
  logic    last;

  modport source (output valid, add_status, has_entry, out_type, out_distance, out_tag,
                  last, input ready);
  modport sink (input valid, add_status, has_entry, out_type, out_distance, out_tag,
                last, output ready);
endinterface

// ----- sv/sil_cell.sv -----
// ----------------------------------------------------------------------------
// sil_cell
// One slot of the sorted list: keeps its entry, takes the new entry or its
// left neighbor on insertion, and takes its right neighbor (or the head at
// the end of the occupied run) on rotation.
// ----------------------------------------------------------------------------
module sil_cell #(
  parameter int IDX = 0,
  parameter int CNT_W = 6,
  parameter int STORE_W = 32
) (
  input  logic                   clk,
  input  sil_pkg::cell_ctrl_t    ctrl,
  input  logic [CNT_W-1:0]       count,
  input  logic [STORE_W-1:0]     new_tag,
  input  logic                   prev_keep,
  input  sil_pkg::dist_t         prev_dist,
  input  logic                   prev_type,
  input  logic [STORE_W-1:0]     prev_tag,
  input  sil_pkg::dist_t         next_dist,
  input  logic                   next_type,
  input  logic [STORE_W-1:0]     next_tag,
  input  sil_pkg::dist_t         head_dist,
  input  logic                   head_type,
  input  logic [STORE_W-1:0]     head_tag,
  output logic                   keep,
  output sil_pkg::dist_t         held_dist,
  output logic                   typ,
  output logic [STORE_W-1:0]     tag
);
  import sil_pkg::*;

  logic occupied;
  logic wrap;

  assign occupied = CNT_W'(IDX) < count;
  assign wrap     = CNT_W'(IDX + 1) == count;
  assign keep     = occupied && (held_dist <= ctrl.new_dist);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (!keep) begin
          if (prev_keep) begin
            held_dist <= ctrl.new_dist;
            typ       <= ctrl.new_type;
            tag       <= new_tag;
          end else begin
            held_dist <= prev_dist;
            typ       <= prev_type;
            tag       <= prev_tag;
          end
        end
      end
      CELL_ROTATE: begin
        if (wrap) begin
          held_dist <= head_dist;
          typ       <= head_type;
          tag       <= head_tag;
        end else begin
          held_dist <= next_dist;
          typ       <= next_type;
          tag       <= next_tag;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/sorted_intercept_list.sv -----
// ----------------------------------------------------------------------------
// sorted_intercept_list
// Intercept list kept sorted by distance in a chain of compare-and-shift
// cells.
// ----------------------------------------------------------------------------
// The req channel carries one operation per transfer: add an entry, clear
// the list, or traverse it. The rsp channel returns the results.
// An add or clear gives a single result, which appears in the output register on
// the cycle after the request transfer, so adds and clears run at one per
// cycle while the receiver keeps up.
// A traverse of n entries gives n results, one per cycle while the receiver
// keeps up; the request first enters the traverse state, from which each
// result is loaded into the output register, with last set on the final one;
// an empty list gives one result with has_entry low. During a traverse the
// cells rotate by one position per result, which sets the rate at one result
// per cycle while the receiver keeps up; no new request is taken until the
// final entry is in the output register. The list ends in its original order.
// When the receiver stalls, the output register holds its result and the
// list holds still; a request is taken only when that register will be free.
// An add whose distance lies outside 0.0 to 1.0 is rejected; an add to a
// full list is rejected with its own status.
// Reset empties the list and drops any pending result.
// ----------------------------------------------------------------------------
module sorted_intercept_list #(
  parameter int CAPACITY = 32,
  parameter int TAG_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  sil_req_if.sink   req,
  sil_rsp_if.source rsp
);
  import sil_pkg::*;
  `include "assert_macros.svh"

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int STORE_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TRAV = 1'b1;

  logic             state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] remain;

  logic slot_free;
  logic accept;
  logic in_range;
  logic full;
  logic do_insert;
  logic do_rotate;
  logic start_trav;
  logic load;

  status_t status_next;
  logic    has_next;
  logic    type_next;
  dist_t   dist_next;
  tag_t    tag_next;
  logic    last_next;

  cell_ctrl_t       ctrl;
  logic [STORE_W-1:0] new_tag;

  logic               keep_q [CAPACITY];
  dist_t              dist_q [CAPACITY];
  logic               type_q [CAPACITY];
  logic [STORE_W-1:0] tag_q  [CAPACITY];

  assign slot_free  = !rsp.valid || rsp.ready;
  assign req.ready  = (state == ST_IDLE) && slot_free;
  assign accept     = req.valid && req.ready;
  assign in_range   = !req.hit_distance[IN_DIST_W-1] &&
                      (req.hit_distance[DIST_W-1:0] <= DIST_ONE);
  assign full       = count == CNT_W'(CAPACITY);
  assign do_insert  = accept && (req.kind == KIND_ADD) && in_range && !full;
  assign do_rotate  = (state == ST_TRAV) && slot_free;
  assign start_trav = accept && (req.kind == KIND_TRAVERSE) && (count != '0);
  assign load       = (accept && !start_trav) || do_rotate;
  assign new_tag    = STORE_W'(req.object_tag);

  always_comb begin
    ctrl.new_dist = req.hit_distance[DIST_W-1:0];
    ctrl.new_type = req.hit_type;
    if (do_insert) begin
      ctrl.op = CELL_INSERT;
    end else if (do_rotate) begin
      ctrl.op = CELL_ROTATE;
    end else begin
      ctrl.op = CELL_HOLD;
    end
  end

  always_comb begin
    status_next = STATUS_NONE;
    has_next    = 1'b0;
    type_next   = 1'b0;
    dist_next   = '0;
    tag_next    = '0;
    last_next   = 1'b1;
    if (state == ST_TRAV) begin
      has_next  = 1'b1;
      type_next = type_q[0];
      dist_next = dist_q[0];
      tag_next  = TAG_W'(tag_q[0]);
      last_next = remain == CNT_W'(1);
    end else if (req.kind == KIND_ADD) begin
      if (!in_range) begin
        status_next = STATUS_RANGE;
      end else if (full) begin
        status_next = STATUS_FULL;
      end else begin
        status_next = STATUS_OK;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               p_keep;
    dist_t              p_dist;
    logic               p_type;
    logic [STORE_W-1:0] p_tag;
    dist_t              n_dist;
    logic               n_type;
    logic [STORE_W-1:0] n_tag;

    if (i == 0) begin : g_first
      assign p_keep = 1'b1;
      assign p_dist = dist_q[0];
      assign p_type = type_q[0];
      assign p_tag  = tag_q[0];
    end else begin : g_mid
      assign p_keep = keep_q[i-1];
      assign p_dist = dist_q[i-1];
      assign p_type = type_q[i-1];
      assign p_tag  = tag_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign n_dist = dist_q[0];
      assign n_type = type_q[0];
      assign n_tag  = tag_q[0];
    end else begin : g_inner
      assign n_dist = dist_q[i+1];
      assign n_type = type_q[i+1];
      assign n_tag  = tag_q[i+1];
    end

    sil_cell #(
      .IDX(i),
      .CNT_W(CNT_W),
      .STORE_W(STORE_W)
    ) u_cell (
      .clk(clk),
      .ctrl(ctrl),
      .count(count),
      .new_tag(new_tag),
      .prev_keep(p_keep),
      .prev_dist(p_dist),
      .prev_type(p_type),
      .prev_tag(p_tag),
      .next_dist(n_dist),
      .next_type(n_type),
      .next_tag(n_tag),
      .head_dist(dist_q[0]),
      .head_type(type_q[0]),
      .head_tag(tag_q[0]),
      .keep(keep_q[i]),
      .held_dist(dist_q[i]),
      .typ(type_q[i]),
      .tag(tag_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remain    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (load) begin
        rsp.add_status   <= status_next;
        rsp.has_entry    <= has_next;
        rsp.out_type     <= type_next;
        rsp.out_distance <= dist_next;
        rsp.out_tag      <= tag_next;
        rsp.last         <= last_next;
      end
      if (do_insert) begin
        count <= count + CNT_W'(1);
      end else if (accept && (req.kind == KIND_CLEAR)) begin
        count <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start_trav) begin
            remain <= count;
            state  <= ST_TRAV;
          end
        end
        ST_TRAV: begin
          if (slot_free) begin
            remain <= remain - CNT_W'(1);
            if (remain == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY), "list count above capacity")
  `ASSERT_ALWAYS(a_trav_nonempty, clk, rst, (state == ST_IDLE) || ((remain != '0) && (remain <= count)), "traverse counter out of range")
  `ASSERT_NEXT(a_insert_count, clk, rst, do_insert, count == $past(count) + CNT_W'(1), "accepted add did not grow the list")
  `ASSERT_NEXT(a_stall_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.out_distance) && $stable(rsp.last), "stalled result changed")

endmodule
